/* rtl/core/wlr_pkg.sv */
`default_nettype none
package wlr_pkg;

    // Timer and register widths.
    localparam int TIMER_BITS = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    // Event kinds carried by an input item.
    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // Reasons a session ends.
    localparam logic [1:0] END_NONE    = 2'd0;
    localparam logic [1:0] END_MAX_LEN = 2'd1;
    localparam logic [1:0] END_SILENCE = 2'd2;
    localparam logic [1:0] END_TIMEOUT = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROMPT_WAIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECORD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROMPT_EN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PROMPT_WAIT_EN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DETECTOR       = 3'd6;

    typedef enum logic [1:0] {
        MODE_WAIT   = 2'd0,
        MODE_LISTEN = 2'd1,
        MODE_RECORD = 2'd2
    } t_mode;

    typedef struct packed {
        logic [CFG_W-1:0] listen_timeout_ms;
        logic [CFG_W-1:0] prompt_wait_ms;
        logic [CFG_W-1:0] silence_limit_ms;
        logic [CFG_W-1:0] max_record_ms;
        logic             prompt_enable;
        logic             prompt_wait_enable;
        logic             detector_present;
    } t_cfg;

    typedef struct packed {
        t_mode                 mode;
        logic                  prompt_hold;
        logic [TIMER_BITS-1:0] prompt_timer;
        logic [TIMER_BITS-1:0] listen_timer;
        logic [TIMER_BITS-1:0] record_timer;
        logic                  silence_armed;
        logic [TIMER_BITS-1:0] silence_timer;
    } t_state;

    typedef struct packed {
        logic [1:0] kind;
        logic       wake_hit;
        logic       speech_hit;
    } t_item;

    typedef struct packed {
        logic [1:0] mode;
        logic       wake_event;
        logic       prompt_request;
        logic       prompt_pending;
        logic       capture_frame;
        logic       capture_done;
        logic [1:0] end_cause;
    } t_result;

    // Saturating increment of one timer.
    function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] t);
        return (t == TIMER_MAX) ? t : t + 1'b1;
    endfunction

    // Timer has reached a limit; both sides are zero extended to a common width.
    function automatic logic reached(input logic [TIMER_BITS-1:0] t,
                                     input logic [CFG_W-1:0] limit);
        return CMP_W'(t) >= CMP_W'(limit);
    endfunction

endpackage
`default_nettype wire

/* rtl/core/wlr_in_if.sv */
`default_nettype none
interface wlr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic       wake_hit;
    logic       speech_hit;

    modport source (output valid, output kind, output wake_hit, output speech_hit,
                    input ready);
    modport sink   (input valid, input kind, input wake_hit, input speech_hit,
                    output ready);
endinterface
`default_nettype wire

/* rtl/core/wlr_out_if.sv */
`default_nettype none
interface wlr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic       wake_event;
    logic       prompt_request;
    logic       prompt_pending;
    logic       capture_frame;
    logic       capture_done;
    logic [1:0] end_cause;

    modport source (output valid, output mode, output wake_event, output prompt_request,
                    output prompt_pending, output capture_frame, output capture_done,
                    output end_cause, input ready);
    modport sink   (input valid, input mode, input wake_event, input prompt_request,
                    input prompt_pending, input capture_frame, input capture_done,
                    input end_cause, output ready);
endinterface
`default_nettype wire

/* rtl/core/wlr_cfg_regs.sv */
`default_nettype none
module wlr_cfg_regs
    import wlr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // Register file with its documented reset values; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.listen_timeout_ms  <= CFG_W'(5000);
            r_cfg.prompt_wait_ms     <= CFG_W'(4000);
            r_cfg.silence_limit_ms   <= CFG_W'(1500);
            r_cfg.max_record_ms      <= CFG_W'(10000);
            r_cfg.prompt_enable      <= 1'b1;
            r_cfg.prompt_wait_enable <= 1'b1;
            r_cfg.detector_present   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LISTEN_TIMEOUT: r_cfg.listen_timeout_ms  <= i_cfg_data;
                CFG_PROMPT_WAIT:    r_cfg.prompt_wait_ms     <= i_cfg_data;
                CFG_SILENCE_LIMIT:  r_cfg.silence_limit_ms   <= i_cfg_data;
                CFG_MAX_RECORD:     r_cfg.max_record_ms      <= i_cfg_data;
                CFG_PROMPT_EN:      r_cfg.prompt_enable      <= i_cfg_data[0];
                CFG_PROMPT_WAIT_EN: r_cfg.prompt_wait_enable <= i_cfg_data[0];
                CFG_DETECTOR:       r_cfg.detector_present   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

/* rtl/core/wlr_step_logic.sv */
`default_nettype none
module wlr_step_logic
    import wlr_pkg::*;
(
    input  t_cfg    i_cfg,
    input  t_state  i_state,
    input  t_item   i_item,
    output t_state  o_state,
    output t_result o_result
);

    t_state n_st;
    logic   go;
    logic   speech;
    logic   done;

    // Next session state and the pulses for one event.
    always_comb begin
        n_st                    = i_state;
        go                      = 1'b1;
        done                    = 1'b0;
        speech                  = i_cfg.detector_present & i_item.speech_hit;
        o_result.wake_event     = 1'b0;
        o_result.prompt_request = 1'b0;
        o_result.capture_frame  = 1'b0;
        o_result.capture_done   = 1'b0;
        o_result.end_cause      = END_NONE;

        case (i_item.kind)
            KIND_TICK: begin
                n_st.prompt_timer  = sat_inc(i_state.prompt_timer);
                n_st.listen_timer  = sat_inc(i_state.listen_timer);
                n_st.record_timer  = sat_inc(i_state.record_timer);
                n_st.silence_timer = sat_inc(i_state.silence_timer);
            end
            KIND_DONE: begin
                if (i_state.prompt_hold) begin
                    n_st.prompt_hold  = 1'b0;
                    n_st.listen_timer = '0;
                end
            end
            KIND_FRAME: begin
                unique case (i_state.mode)
                    MODE_LISTEN: begin
                        // A held frame is dropped until the prompt wait runs out.
                        if (i_state.prompt_hold) begin
                            if (!reached(i_state.prompt_timer, i_cfg.prompt_wait_ms)) begin
                                go = 1'b0;
                            end else begin
                                n_st.prompt_hold  = 1'b0;
                                n_st.listen_timer = '0;
                            end
                        end
                        if (go) begin
                            if (!i_cfg.detector_present || i_item.speech_hit) begin
                                n_st.record_timer      = '0;
                                n_st.silence_armed     = 1'b0;
                                n_st.mode              = MODE_RECORD;
                                o_result.capture_frame = 1'b1;
                            end else if (reached(n_st.listen_timer,
                                                 i_cfg.listen_timeout_ms)) begin
                                n_st.mode          = MODE_WAIT;
                                o_result.end_cause = END_TIMEOUT;
                            end
                        end
                    end
                    MODE_RECORD: begin
                        o_result.capture_frame = 1'b1;
                        if (reached(i_state.record_timer, i_cfg.max_record_ms)) begin
                            done               = 1'b1;
                            o_result.end_cause = END_MAX_LEN;
                        end else if (speech) begin
                            n_st.silence_armed = 1'b0;
                        end else if (!i_state.silence_armed) begin
                            n_st.silence_armed = 1'b1;
                            n_st.silence_timer = '0;
                        end else if (reached(i_state.silence_timer,
                                             i_cfg.silence_limit_ms)) begin
                            done               = 1'b1;
                            o_result.end_cause = END_SILENCE;
                        end
                        if (done) begin
                            n_st.silence_armed = 1'b0;
                            n_st.mode          = MODE_WAIT;
                        end
                        o_result.capture_done = done;
                    end
                    default: begin
                        // Waiting: a wake hit opens the listen window.
                        if (i_item.wake_hit) begin
                            o_result.wake_event     = 1'b1;
                            o_result.prompt_request = i_cfg.prompt_enable;
                            n_st.prompt_hold  = i_cfg.prompt_enable & i_cfg.prompt_wait_enable;
                            n_st.prompt_timer = '0;
                            n_st.listen_timer = '0;
                            n_st.mode         = MODE_LISTEN;
                        end
                    end
                endcase
            end
            default: ;
        endcase

        o_result.mode           = n_st.mode;
        o_result.prompt_pending = n_st.prompt_hold;
    end

    assign o_state = n_st;

endmodule
`default_nettype wire

/* rtl/core/wake_listen_record_controller_unit.sv */
`default_nettype none
// Voice capture session controller. Each accepted item (audio frame, prompt
// playback done, millisecond tick, or the unused kind code) produces exactly one
// result item that reports the mode after the event and its pulses. One item is
// taken per clock cycle when the result side keeps up. An accepted item is held
// in the input register, and its result is then held in the result register
// until it is taken. The rate is set by the session state update, which is
// combinational between those two registers.
// While a finished result waits for the consumer, one more item can still be
// taken into an empty input register; after that the input stalls until the
// result is taken. The user must write configuration registers through the
// plain write port only while the block is idle; the block does not enforce
// this. A write to an index beyond the register list is ignored.
module wake_listen_record_controller_unit
    import wlr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    wlr_in_if.sink               i_evt,
    wlr_out_if.source            o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg    w_cfg;
    t_state  r_state;
    t_state  n_state;
    t_item   r_item;
    t_result r_res;
    t_result n_res;
    logic    r_item_valid;
    logic    r_res_valid;
    logic    w_advance;

    wlr_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    wlr_step_logic u_step (
        .i_cfg    (w_cfg),
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_res)
    );

    // The result register moves on when it is empty or being taken.
    assign w_advance   = !r_res_valid || o_res.ready;
    assign i_evt.ready = !r_item_valid || w_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (i_evt.ready) begin
            r_item_valid <= i_evt.valid;
        end
        if (i_evt.valid && i_evt.ready) begin
            r_item.kind       <= i_evt.kind;
            r_item.wake_hit   <= i_evt.wake_hit;
            r_item.speech_hit <= i_evt.speech_hit;
        end
    end

    // Session state and result register update together as an item retires.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid           <= 1'b0;
            r_state.mode          <= MODE_WAIT;
            r_state.prompt_hold   <= 1'b0;
            r_state.prompt_timer  <= '0;
            r_state.listen_timer  <= '0;
            r_state.record_timer  <= '0;
            r_state.silence_armed <= 1'b0;
            r_state.silence_timer <= '0;
        end else if (w_advance) begin
            r_res_valid <= r_item_valid;
            if (r_item_valid) begin
                r_state <= n_state;
            end
        end
        if (w_advance && r_item_valid) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid          = r_res_valid;
    assign o_res.mode           = r_res.mode;
    assign o_res.wake_event     = r_res.wake_event;
    assign o_res.prompt_request = r_res.prompt_request;
    assign o_res.prompt_pending = r_res.prompt_pending;
    assign o_res.capture_frame  = r_res.capture_frame;
    assign o_res.capture_done   = r_res.capture_done;
    assign o_res.end_cause      = r_res.end_cause;

endmodule
`default_nettype wire

/* sim/tb.sv */
`default_nettype none
module tb
    import wlr_pkg::*;
;

    // Kind code that the block leaves unused, and a register index past the list.
    localparam logic [1:0]           KIND_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    // Receiver stall patterns.
    localparam int PAT_OPEN   = 0;
    localparam int PAT_COIN   = 1;
    localparam int PAT_COMB   = 2;
    localparam int PAT_HOLD   = 3;
    localparam int HOLD_LEN   = 400;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 240;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_op;

    typedef struct {
        t_row_op              op;
        t_item                it;
        logic                 typed;
        t_result              want;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    wlr_in_if  evt_if();
    wlr_out_if res_if();

    wake_listen_record_controller_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_evt      (evt_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Session model: registers and state as the block should hold them.
    t_cfg    cfg_m;
    t_state  sess;
    t_result status_q[$];
    t_row    plan[$];
    int      bad_results = 0;
    int      burst_left  = 0;
    logic    hold_off_req = 1'b0;

    function automatic logic [TIMER_BITS-1:0] tick_up(input logic [TIMER_BITS-1:0] t);
        return (&t) ? t : t + 1'b1;
    endfunction

    // Apply one event to the session model and return the status it reports.
    function automatic t_result predict_session(input t_item it);
        t_result r;
        logic    go;
        r  = '0;
        go = 1'b1;
        case (it.kind)
            KIND_TICK: begin
                sess.prompt_timer  = tick_up(sess.prompt_timer);
                sess.listen_timer  = tick_up(sess.listen_timer);
                sess.record_timer  = tick_up(sess.record_timer);
                sess.silence_timer = tick_up(sess.silence_timer);
            end
            KIND_DONE: begin
                if (sess.prompt_hold) begin
                    sess.prompt_hold  = 1'b0;
                    sess.listen_timer = '0;
                end
            end
            KIND_FRAME: begin
                case (sess.mode)
                    MODE_LISTEN: begin
                        // A held frame is dropped until the prompt wait runs out.
                        if (sess.prompt_hold) begin
                            if (sess.prompt_timer < cfg_m.prompt_wait_ms) begin
                                go = 1'b0;
                            end else begin
                                sess.prompt_hold  = 1'b0;
                                sess.listen_timer = '0;
                            end
                        end
                        if (go) begin
                            if (!cfg_m.detector_present || it.speech_hit) begin
                                sess.record_timer  = '0;
                                sess.silence_armed = 1'b0;
                                sess.mode          = MODE_RECORD;
                                r.capture_frame    = 1'b1;
                            end else if (sess.listen_timer >= cfg_m.listen_timeout_ms) begin
                                sess.mode   = MODE_WAIT;
                                r.end_cause = END_TIMEOUT;
                            end
                        end
                    end
                    MODE_RECORD: begin
                        r.capture_frame = 1'b1;
                        if (sess.record_timer >= cfg_m.max_record_ms) begin
                            r.capture_done = 1'b1;
                            r.end_cause    = END_MAX_LEN;
                        end else if (cfg_m.detector_present && it.speech_hit) begin
                            sess.silence_armed = 1'b0;
                        end else if (!sess.silence_armed) begin
                            sess.silence_armed = 1'b1;
                            sess.silence_timer = '0;
                        end else if (sess.silence_timer >= cfg_m.silence_limit_ms) begin
                            r.capture_done = 1'b1;
                            r.end_cause    = END_SILENCE;
                        end
                        if (r.capture_done) begin
                            sess.silence_armed = 1'b0;
                            sess.mode          = MODE_WAIT;
                        end
                    end
                    default: begin
                        if (it.wake_hit) begin
                            r.wake_event      = 1'b1;
                            r.prompt_request  = cfg_m.prompt_enable;
                            sess.prompt_hold  = cfg_m.prompt_enable & cfg_m.prompt_wait_enable;
                            sess.prompt_timer = '0;
                            sess.listen_timer = '0;
                            sess.mode         = MODE_LISTEN;
                        end
                    end
                endcase
            end
            default: ;
        endcase
        r.mode           = sess.mode;
        r.prompt_pending = sess.prompt_hold;
        return r;
    endfunction

    function automatic t_item mk_item(input logic [1:0] kind, input logic wake,
                                      input logic speech);
        t_item it;
        it.kind       = kind;
        it.wake_hit   = wake;
        it.speech_hit = speech;
        return it;
    endfunction

    function automatic t_result mk_res(input t_mode mode, input logic wake, input logic req,
                                       input logic pend, input logic cap, input logic done,
                                       input logic [1:0] cause);
        t_result r;
        r.mode           = mode;
        r.wake_event     = wake;
        r.prompt_request = req;
        r.prompt_pending = pend;
        r.capture_frame  = cap;
        r.capture_done   = done;
        r.end_cause      = cause;
        return r;
    endfunction

    // Directed table entries.
    function automatic void add_item(input logic [1:0] kind, input logic wake,
                                     input logic speech);
        t_row row;
        row.op    = ROW_ITEM;
        row.it    = mk_item(kind, wake, speech);
        row.typed = 1'b0;
        row.want  = '0;
        row.idx   = '0;
        row.data  = '0;
        plan      = {plan, row};
    endfunction

    function automatic void add_check(input logic [1:0] kind, input logic wake,
                                      input logic speech, input t_result want);
        t_row row;
        row.op    = ROW_ITEM;
        row.it    = mk_item(kind, wake, speech);
        row.typed = 1'b1;
        row.want  = want;
        row.idx   = '0;
        row.data  = '0;
        plan      = {plan, row};
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] data);
        t_row row;
        row.op    = ROW_CFG;
        row.it    = '0;
        row.typed = 1'b0;
        row.want  = '0;
        row.idx   = idx;
        row.data  = data;
        plan      = {plan, row};
    endfunction

    // Offer one item; on acceptance record what the block should answer.
    task automatic send_item(input t_item it, input logic typed, input t_result want);
        int      gap;
        t_result calc;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                evt_if.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        evt_if.kind       = it.kind;
        evt_if.wake_hit   = it.wake_hit;
        evt_if.speech_hit = it.speech_hit;
        evt_if.valid      = 1'b1;
        do @(posedge i_clk); while (evt_if.ready !== 1'b1);
        calc = predict_session(it);
        status_q = {status_q, (typed ? want : calc)};
        @(negedge i_clk);
    endtask

    // Wait for every outstanding result, then let the pipeline settle.
    task automatic drain();
        evt_if.valid = 1'b0;
        while (status_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        case (idx)
            CFG_LISTEN_TIMEOUT: cfg_m.listen_timeout_ms  = data;
            CFG_PROMPT_WAIT:    cfg_m.prompt_wait_ms     = data;
            CFG_SILENCE_LIMIT:  cfg_m.silence_limit_ms   = data;
            CFG_MAX_RECORD:     cfg_m.max_record_ms      = data;
            CFG_PROMPT_EN:      cfg_m.prompt_enable      = data[0];
            CFG_PROMPT_WAIT_EN: cfg_m.prompt_wait_enable = data[0];
            CFG_DETECTOR:       cfg_m.detector_present   = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we = 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly short limits so sessions turn over, with the extremes now and then.
    function automatic logic [CFG_W-1:0] pick_limit();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return CFG_W'($urandom_range(1, 12));
    endfunction

    function automatic logic [CFG_W-1:0] pick_flag();
        logic [CFG_W-1:0] d;
        d    = CFG_W'($urandom_range(0, 65535));
        d[0] = ($urandom_range(0, 3) != 0);
        return d;
    endfunction

    // Random event steered by the current session mode.
    function automatic t_item pick_item();
        int   r;
        logic wake;
        logic speech;
        r      = $urandom_range(0, 99);
        speech = 1'($urandom_range(0, 1));
        wake   = (sess.mode == MODE_WAIT) ? ($urandom_range(0, 4) < 2)
                                          : ($urandom_range(0, 9) == 0);
        if (r < 3) return mk_item(KIND_SPARE, wake, speech);
        if (r < 42) return mk_item(KIND_TICK, wake, speech);
        if (r < 48 || (sess.prompt_hold && r < 60)) return mk_item(KIND_DONE, wake, speech);
        return mk_item(KIND_FRAME, wake, speech);
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            got.mode           = res_if.mode;
            got.wake_event     = res_if.wake_event;
            got.prompt_request = res_if.prompt_request;
            got.prompt_pending = res_if.prompt_pending;
            got.capture_frame  = res_if.capture_frame;
            got.capture_done   = res_if.capture_done;
            got.end_cause      = res_if.end_cause;
            if (status_q.size() == 0) begin
                bad_results++;
                if (bad_results <= 10) begin
                    $display("unexpected status item: mode=%0d cause=%0d", got.mode,
                             got.end_cause);
                end
            end else begin
                want = status_q.pop_front();
                if (got.mode !== want.mode || got.wake_event !== want.wake_event ||
                    got.prompt_request !== want.prompt_request ||
                    got.prompt_pending !== want.prompt_pending ||
                    got.capture_frame !== want.capture_frame ||
                    got.capture_done !== want.capture_done ||
                    got.end_cause !== want.end_cause) begin
                    bad_results++;
                    if (bad_results <= 10) begin
                        $display("status mismatch: expected mode=%0d wake=%b req=%b pend=%b",
                                 want.mode, want.wake_event, want.prompt_request,
                                 want.prompt_pending, " cap=%b done=%b cause=%0d;",
                                 want.capture_frame, want.capture_done, want.end_cause,
                                 " actual mode=%0d wake=%b req=%b pend=%b",
                                 got.mode, got.wake_event, got.prompt_request,
                                 got.prompt_pending, " cap=%b done=%b cause=%0d",
                                 got.capture_frame, got.capture_done, got.end_cause);
                    end
                end
            end
        end
    end

    // Receiver: stretches of always-ready, coin-flip and comb stalls, plus one long hold.
    initial begin
        int   pat;
        int   len;
        int   k;
        logic hold_used;
        hold_used    = 1'b0;
        res_if.ready = 1'b0;
        forever begin
            pat = $urandom_range(PAT_OPEN, PAT_COMB);
            len = $urandom_range(4, 48);
            if (hold_off_req && !hold_used) begin
                hold_used = 1'b1;
                pat       = PAT_HOLD;
                len       = HOLD_LEN;
            end
            for (k = 0; k < len; k++) begin
                @(negedge i_clk);
                case (pat)
                    PAT_OPEN: res_if.ready = 1'b1;
                    PAT_COIN: res_if.ready = 1'($urandom_range(0, 1));
                    PAT_COMB: res_if.ready = (k % 4 != 3);
                    default:  res_if.ready = 1'b0;
                endcase
            end
        end
    end

    // Run limit.
    initial begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Stimulus.
    initial begin
        int   n;
        int   ph;
        t_row row;
        i_rst_n           = 1'b0;
        evt_if.valid      = 1'b0;
        evt_if.kind       = KIND_FRAME;
        evt_if.wake_hit   = 1'b0;
        evt_if.speech_hit = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = CFG_LISTEN_TIMEOUT;
        cfg_data          = '0;
        sess              = '0;
        cfg_m.listen_timeout_ms  = 16'd5000;
        cfg_m.prompt_wait_ms     = 16'd4000;
        cfg_m.silence_limit_ms   = 16'd1500;
        cfg_m.max_record_ms      = 16'd10000;
        cfg_m.prompt_enable      = 1'b1;
        cfg_m.prompt_wait_enable = 1'b1;
        cfg_m.detector_present   = 1'b1;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Idle after reset, ignored events, a prompted session that records.
        add_check(KIND_TICK, 1'b1, 1'b1,
                  mk_res(MODE_WAIT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, END_NONE));
        add_check(KIND_DONE, 1'b0, 1'b0,
                  mk_res(MODE_WAIT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, END_NONE));
        add_check(KIND_SPARE, 1'b1, 1'b0,
                  mk_res(MODE_WAIT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, END_NONE));
        add_item(KIND_FRAME, 1'b0, 1'b1);
        add_check(KIND_FRAME, 1'b1, 1'b0,
                  mk_res(MODE_LISTEN, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, END_NONE));
        add_item(KIND_FRAME, 1'b0, 1'b1);
        add_item(KIND_FRAME, 1'b1, 1'b0);
        add_item(KIND_DONE, 1'b0, 1'b0);
        add_item(KIND_FRAME, 1'b0, 1'b1);
        add_item(KIND_TICK, 1'b0, 1'b0);
        add_item(KIND_FRAME, 1'b0, 1'b0);
        // A zero length limit ends the recording at once.
        add_cfg(CFG_MAX_RECORD, 16'd0);
        add_check(KIND_FRAME, 1'b0, 1'b1,
                  mk_res(MODE_WAIT, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, END_MAX_LEN));
        // No detector and no prompt: speech is ignored, silence of zero ends it.
        add_cfg(CFG_SILENCE_LIMIT, 16'd0);
        add_cfg(CFG_MAX_RECORD, 16'hFFFF);
        add_cfg(CFG_PROMPT_EN, 16'd0);
        add_cfg(CFG_DETECTOR, 16'd0);
        add_item(KIND_FRAME, 1'b1, 1'b0);
        add_item(KIND_FRAME, 1'b0, 1'b0);
        add_item(KIND_FRAME, 1'b0, 1'b1);
        add_item(KIND_FRAME, 1'b0, 1'b1);
        // Prompt without hold and a zero listen window.
        add_cfg(CFG_LISTEN_TIMEOUT, 16'd0);
        add_cfg(CFG_DETECTOR, 16'd1);
        add_cfg(CFG_PROMPT_EN, 16'd1);
        add_cfg(CFG_PROMPT_WAIT_EN, 16'd0);
        add_item(KIND_FRAME, 1'b1, 1'b0);
        add_check(KIND_FRAME, 1'b0, 1'b0,
                  mk_res(MODE_WAIT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, END_TIMEOUT));
        // Hold with a zero prompt wait, then a short listen window runs out.
        add_cfg(CFG_PROMPT_WAIT_EN, 16'd1);
        add_cfg(CFG_PROMPT_WAIT, 16'd0);
        add_cfg(CFG_LISTEN_TIMEOUT, 16'd2);
        add_item(KIND_FRAME, 1'b1, 1'b1);
        add_item(KIND_FRAME, 1'b0, 1'b0);
        add_item(KIND_TICK, 1'b0, 1'b0);
        add_item(KIND_TICK, 1'b0, 1'b0);
        add_item(KIND_FRAME, 1'b0, 1'b0);
        add_item(KIND_SPARE, 1'b1, 1'b1);

        foreach (plan[i]) begin
            row = plan[i];
            if (row.op == ROW_CFG) begin
                drain();
                write_reg(row.idx, row.data);
            end else begin
                send_item(row.it, row.typed, row.want);
            end
        end

        // Random phases, each under a fresh register setting.
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            drain();
            write_reg(CFG_LISTEN_TIMEOUT, pick_limit());
            write_reg(CFG_PROMPT_WAIT, pick_limit());
            write_reg(CFG_SILENCE_LIMIT, pick_limit());
            write_reg(CFG_MAX_RECORD, pick_limit());
            write_reg(CFG_PROMPT_EN, pick_flag());
            write_reg(CFG_PROMPT_WAIT_EN, pick_flag());
            write_reg(CFG_DETECTOR, pick_flag());
            if ($urandom_range(0, 1) == 1) begin
                write_reg(CFG_UNUSED, CFG_W'($urandom_range(0, 65535)));
            end
            if (ph == 1) begin
                hold_off_req = 1'b1;
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                send_item(pick_item(), 1'b0, '0);
            end
        end

        drain();
        repeat (10) @(negedge i_clk);
        if (bad_results == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* files.f */
rtl/core/wlr_pkg.sv
rtl/core/wlr_in_if.sv
rtl/core/wlr_out_if.sv
rtl/core/wlr_cfg_regs.sv
rtl/core/wlr_step_logic.sv
rtl/core/wake_listen_record_controller_unit.sv
sim/tb.sv
